// ----- sv/supl_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types
// for the shortest unique pattern length unit. No dependencies.
package supl_pkg;

  // Storage sizes.
  localparam int BUFFER_DEPTH = 65536;
  localparam int MAX_PATTERN  = 64;

  // Derived widths.
  localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

  // Field widths fixed by the interface.
  localparam int TGT_W     = 16;
  localparam int CFG_LEN_W = 7;
  localparam int OUT_W     = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Common width for comparing counts, offsets and lengths.
  localparam int CMP_A = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int CMP_B = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int CMP_W = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN       = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // Store an accepted byte.
    logic setup;     // Latch the clamped length window.
    logic copy_wr;   // Write one pattern byte, step the copy index.
    logic pos_skip;  // Step past the target position.
    logic cmp_rd;    // Address the store at the scan position.
    logic cmp_chk;   // Compare one byte, step or close the position.
    logic out_load;  // Load the result register.
  } supl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_target;  // Target lies beyond the buffer (valid in setup).
    logic hi_zero;     // Clamped max length is zero (valid in setup).
    logic copy_last;   // Final pattern byte is being written.
    logic pos_done;    // All positions scanned.
    logic pos_skip;    // Scan position is the target itself.
    logic mmax_full;   // Some other position already matches the longest length.
    logic match_go;    // Byte matched and the prefix may grow further.
  } supl_stat_t;

endpackage

// ----- sv/supl_ctrl.sv -----
// Controller state machine for the shortest unique pattern length unit.
// Depends on supl_pkg for the command and status types.
module supl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_byte,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  supl_pkg::supl_stat_t stat,
  output supl_pkg::supl_cmd_t  cmd
);
  import supl_pkg::*;

  typedef enum logic [7:0] {
    ST_LOAD    = 8'b0000_0001,
    ST_SETUP   = 8'b0000_0010,
    ST_COPY_RD = 8'b0000_0100,
    ST_COPY_WR = 8'b0000_1000,
    ST_POS     = 8'b0001_0000,
    ST_CMP_RD  = 8'b0010_0000,
    ST_CMP_CHK = 8'b0100_0000,
    ST_FINISH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Bytes are taken only while loading; the search holds the input off.
  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last_byte) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.bad_target || stat.hi_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = stat.copy_last ? ST_POS : ST_COPY_RD;
      end
      ST_POS: begin
        if (stat.pos_done || stat.mmax_full) begin
          state_nxt = ST_FINISH;
        end else if (stat.pos_skip) begin
          cmd.pos_skip = 1'b1;
        end else begin
          state_nxt = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        cmd.cmp_chk = 1'b1;
        state_nxt   = stat.match_go ? ST_CMP_RD : ST_POS;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // The result register is full from its load until the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/supl_dp.sv -----
// Datapath for the shortest unique pattern length unit: configuration
// registers, byte store, pattern copy, scan counters and result register.
// Depends on supl_pkg for widths and the command and status types.
module supl_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [supl_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [supl_pkg::CFG_W-1:0]               cfg_wdata,
  input  logic [7:0]                               in_data_byte,
  input  logic                                     in_last_byte,
  input  supl_pkg::supl_cmd_t                      cmd,
  output supl_pkg::supl_stat_t                     stat,
  output logic [supl_pkg::OUT_W-1:0]               out_unique_len
);
  import supl_pkg::*;

  // Configuration registers.
  logic [TGT_W-1:0]     target_r;
  logic [CFG_LEN_W-1:0] min_len_r;
  logic [CFG_LEN_W-1:0] max_len_r;

  // Buffer and pattern storage.
  logic [7:0] store_mem [BUFFER_DEPTH];
  logic [7:0] pat_mem   [MAX_PATTERN];
  logic [7:0] store_rdata_r;
  logic [7:0] pat_rdata_r;

  // Counters and search state.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] pos_r;
  logic [LEN_W-1:0] k_r;
  logic [LEN_W-1:0] hi_r;
  logic [LEN_W-1:0] lo_r;
  logic [LEN_W-1:0] mmax_r;
  logic             bad_r;
  logic [OUT_W-1:0] out_unique_len_r;

  logic             store_ok;
  logic [CMP_W-1:0] n_w, t_w, avail_c, hi_a, hi_c, lo_a, lo_c;
  logic             bad_c;
  logic [BUF_AW-1:0] rd_addr;
  logic [CNT_W-1:0]  scan_sum;
  logic [LEN_W-1:0]  k_inc;
  logic              match, k_last;
  logic [LEN_W-1:0]  lcp;
  logic [LEN_W-1:0]  cand;
  logic [LEN_W-1:0]  res_len;
  logic [OUT_W-1:0]  res;

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= TGT_W'(0);
      min_len_r <= CFG_LEN_W'(5);
      max_len_r <= CFG_LEN_W'(21);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_OFFSET: target_r  <= cfg_wdata[TGT_W-1:0];
        REG_MIN_LEN:       min_len_r <= cfg_wdata[CFG_LEN_W-1:0];
        REG_MAX_LEN:       max_len_r <= cfg_wdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Bytes past the store's depth are dropped.
  assign store_ok = (count_r < CNT_W'(BUFFER_DEPTH));

  // Clamp the length window from the buffer size and the registers.
  assign n_w     = CMP_W'(n_r);
  assign t_w     = CMP_W'(target_r);
  assign bad_c   = (t_w >= n_w);
  assign avail_c = n_w - t_w;
  assign hi_a    = (CMP_W'(max_len_r) < avail_c) ? CMP_W'(max_len_r) : avail_c;
  assign hi_c    = (hi_a > CMP_W'(MAX_PATTERN)) ? CMP_W'(MAX_PATTERN) : hi_a;
  assign lo_a    = (min_len_r == '0) ? CMP_W'(1) : CMP_W'(min_len_r);
  assign lo_c    = (lo_a > hi_c) ? hi_c : lo_a;

  // Store address: scan position plus prefix index, or target plus copy index.
  assign k_inc    = LEN_W'(k_r + 1'b1);
  assign scan_sum = CNT_W'(pos_r + CNT_W'(k_r));
  assign rd_addr  = cmd.cmp_rd ? scan_sum[BUF_AW-1:0] : BUF_AW'(t_w + CMP_W'(k_r));

  // Byte store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      store_mem[count_r[BUF_AW-1:0]] <= in_data_byte;
    end
    store_rdata_r <= store_mem[rd_addr];
  end

  // Pattern copy, indexed by the prefix counter.
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      pat_mem[k_r[PAT_AW-1:0]] <= store_rdata_r;
    end
    pat_rdata_r <= pat_mem[k_r[PAT_AW-1:0]];
  end

  // Compare one byte of the prefix at the scan position.
  assign match  = (store_rdata_r == pat_rdata_r);
  assign k_last = (k_inc >= hi_r) || (CNT_W'(scan_sum + 1'b1) >= n_r);
  assign lcp    = match ? k_inc : k_r;

  // Buffer fill count and buffer size of the finished load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      if (in_last_byte) begin
        count_r <= '0;
      end else if (store_ok) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_last_byte) begin
      n_r <= CNT_W'(count_r + CNT_W'(store_ok));
    end
  end

  // Search counters: copy index, scan position and longest foreign match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      pos_r  <= '0;
      mmax_r <= '0;
      hi_r   <= '0;
      lo_r   <= '0;
      bad_r  <= 1'b0;
    end else if (cmd.setup) begin
      k_r    <= '0;
      pos_r  <= '0;
      mmax_r <= '0;
      hi_r   <= LEN_W'(hi_c);
      lo_r   <= LEN_W'(lo_c);
      bad_r  <= bad_c;
    end else if (cmd.copy_wr) begin
      k_r <= stat.copy_last ? '0 : k_inc;
    end else if (cmd.pos_skip) begin
      pos_r <= CNT_W'(pos_r + 1'b1);
    end else if (cmd.cmp_chk) begin
      if (stat.match_go) begin
        k_r <= k_inc;
      end else begin
        k_r   <= '0;
        pos_r <= CNT_W'(pos_r + 1'b1);
        if (lcp > mmax_r) begin
          mmax_r <= lcp;
        end
      end
    end
  end

  // Shortest length that no other position matches, within the window; min_len for a bad target.
  assign cand    = LEN_W'(mmax_r + 1'b1);
  assign res_len = stat.mmax_full ? hi_r : ((cand > lo_r) ? cand : lo_r);
  assign res     = bad_r ? OUT_W'(min_len_r) : OUT_W'(res_len);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_unique_len_r <= res;
    end
  end

  assign out_unique_len = out_unique_len_r;

  // Status toward the controller.
  always_comb begin
    stat.bad_target = bad_c;
    stat.hi_zero    = (hi_c == '0);
    stat.copy_last  = (k_inc == hi_r);
    stat.pos_done   = (pos_r >= n_r);
    stat.pos_skip   = (CMP_W'(pos_r) == t_w);
    stat.mmax_full  = (mmax_r >= hi_r);
    stat.match_go   = match && !k_last;
  end

endmodule

// ----- sv/shortest_unique_pattern_length_unit.sv -----
// Shortest unique pattern length unit: top level joining controller and datapath.
// Depends on supl_pkg, supl_ctrl and supl_dp.
//
// The unit loads a byte buffer at one byte per cycle; the byte flagged as last
// ends the buffer and starts a search for the shortest length, within the
// clamped min_len..max_len window, at which the pattern at target_offset occurs
// only once. During the search in_stall stays high. A setup state is followed
// by a copy of the H pattern bytes (H is the clamped max length), each read
// and then written. Each buffer position is then visited, with a read and a
// check per compared byte: P+1 bytes where a mismatch ends a common prefix of
// length P, P bytes where the prefix runs into H or into the end of the buffer.
// The target's own position is skipped without a compare. The scan stops
// early once some position matches all H bytes. The result then goes to the
// output register, held back while a previous result is stalled. A target
// beyond the buffer or a zero max length skips the copy and the scan. The byte
// store is read once per compared byte. The result waits in an output register,
// so the next buffer can load while it is pending. Configuration registers
// must be written by the user while the unit is idle; this is not enforced.
module shortest_unique_pattern_length_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [supl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [supl_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [supl_pkg::OUT_W-1:0]         out_unique_len
);
  import supl_pkg::*;

  supl_cmd_t  cmd;
  supl_stat_t stat;

  // Sequencing of load, copy, scan and result hand-off.
  supl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Storage, counters and compare logic.
  supl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_unique_len (out_unique_len)
  );

endmodule
